>>> hw/rtl/paid_pkg.sv
// Shared types for the positional array insert/delete unit.
// Holds the operation and status codes, the controller states and the command and status groups.
// Has no dependencies.
`default_nettype none

package paid_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 48;
   localparam int POS_W      = 5;
   localparam int WORD_W     = 32;

   typedef enum logic [2:0] {
      KIND_INSERT  = 3'd0,
      KIND_DELETE  = 3'd1,
      KIND_SEARCH  = 3'd2,
      KIND_UPDATE  = 3'd3,
      KIND_DISPLAY = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_POS   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_DISPLAY
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic compare;
      logic search_done;
      logic disp_step;
   } cmd_type;

   typedef struct packed {
      logic is_search;
      logic is_display_run;
      logic disp_last;
   } stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/paid_ctrl.sv
// Controller state machine of the positional array insert/delete unit.
// Drives the request and response handshakes and sequences the datapath; uses paid_pkg.
`default_nettype none

module paid_ctrl
   import paid_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load_rsp;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = cmd.exec || cmd.search_done || cmd.disp_step;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (stat.is_search) begin
               state_in = ST_SEARCH;
            end else if (stat.is_display_run) begin
               state_in = ST_DISPLAY;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_DISPLAY: begin
            if (out_free && stat.disp_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_DECODE: begin
            cmd.compare = stat.is_search;
            cmd.exec    = !stat.is_search && !stat.is_display_run && out_free;
         end
         ST_SEARCH: begin
            cmd.search_done = out_free;
         end
         ST_DISPLAY: begin
            cmd.disp_step = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.exec, cmd.compare, cmd.search_done, cmd.disp_step}))
      else $error("more than one datapath command at once");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> out_free)
      else $error("response register loaded while a response is still pending");

   a_disp_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.disp_step && stat.disp_last) |=> (state_ff == ST_IDLE))
      else $error("display did not end after its last word");

endmodule

`default_nettype wire

>>> hw/rtl/paid_dpath.sv
// Datapath of the positional array insert/delete unit: request register, word cell chain,
// word count, match vector and response register. Uses paid_pkg.
`default_nettype none

module paid_dpath
   import paid_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [REQ_USER_W-1:0] kind_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [WORD_W-1:0]     value_ff;

   logic [WORD_W-1:0]     cell_ff [DEPTH];
   logic [WORD_W-1:0]     cell_in [DEPTH];
   logic [CW-1:0]         count_ff, count_in;
   logic [DEPTH-1:0]      match_ff, match_in;
   logic [IW-1:0]         disp_idx_ff, disp_idx_in;

   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [POS_W-1:0]      rsp_count_ff;
   logic                  rsp_last_ff, rsp_last_in;

   logic [XW-1:0]         pos_x, count_x, count_new_x, disp_pos_x, hit_pos_x;
   logic                  pos_in_list, pos_in_room;
   logic [IW-1:0]         hit_idx;
   logic                  hit;

   assign pos_x       = XW'(pos_ff);
   assign count_x     = XW'(count_ff);
   assign pos_in_list = (pos_ff != '0) && (pos_x <= count_x);
   assign pos_in_room = (pos_ff != '0) && (pos_x <= count_x + XW'(1));
   assign disp_pos_x  = XW'(disp_idx_ff) + XW'(1);
   assign hit_pos_x   = XW'(hit_idx) + XW'(1);
   assign count_new_x = XW'(count_in);

   assign stat.is_search      = (kind_ff == KIND_SEARCH);
   assign stat.is_display_run = (kind_ff == KIND_DISPLAY) && (count_ff != '0);
   assign stat.disp_last      = (disp_pos_x == count_x);

   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IW'(i);
      end
   end
   assign hit = |match_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (cell_ff[i] == value_ff) && (XW'(i) < count_x);
      end
   end

   always_comb begin
      cell_in       = cell_ff;
      count_in      = count_ff;
      disp_idx_in   = disp_idx_ff;
      rsp_status_in = STATUS_OK;
      rsp_pos_in    = '0;
      rsp_word_in   = '0;
      rsp_last_in   = 1'b1;
      if (cmd.load_req) begin
         disp_idx_in = '0;
      end
      if (cmd.exec) begin
         case (kind_ff)
            KIND_INSERT: begin
               if (!pos_in_room) begin
                  rsp_status_in = STATUS_BAD_POS;
               end else if (count_x == XW'(DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (XW'(i) + XW'(1) == pos_x) begin
                        cell_in[i] = value_ff;
                     end else if (XW'(i) >= pos_x) begin
                        cell_in[i] = cell_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_DELETE: begin
               if (!pos_in_list) begin
                  rsp_status_in = STATUS_BAD_POS;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (XW'(i) + XW'(1) >= pos_x) begin
                        cell_in[i] = cell_ff[(i == DEPTH - 1) ? i : i + 1];
                     end
                  end
                  count_in = count_ff - CW'(1);
               end
            end
            KIND_UPDATE: begin
               if (!pos_in_list) begin
                  rsp_status_in = STATUS_BAD_POS;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (XW'(i) + XW'(1) == pos_x) cell_in[i] = value_ff;
                  end
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
      if (cmd.search_done) begin
         rsp_status_in = hit ? STATUS_OK : STATUS_NOT_FOUND;
         rsp_pos_in    = hit ? hit_pos_x[POS_W-1:0] : '0;
      end
      if (cmd.disp_step) begin
         rsp_pos_in  = disp_pos_x[POS_W-1:0];
         rsp_word_in = cell_ff[0];
         rsp_last_in = stat.disp_last;
         disp_idx_in = disp_idx_ff + IW'(1);
         for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) + XW'(1) == count_x) begin
               cell_in[i] = cell_ff[0];
            end else if (XW'(i) + XW'(1) < count_x) begin
               cell_in[i] = cell_ff[(i == DEPTH - 1) ? i : i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      disp_idx_ff <= disp_idx_in;
      if (cmd.load_req) begin
         kind_ff  <= req_tuser;
         pos_ff   <= req_tdata[POS_W-1:0];
         value_ff <= req_tdata[POS_W+WORD_W-1:POS_W];
      end
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.exec || cmd.search_done || cmd.disp_step) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_count_ff  <= count_new_x[POS_W-1:0];
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tdata = {4'b0000, rsp_count_ff, rsp_word_ff, rsp_pos_ff, rsp_status_ff};
   assign rsp_tlast = rsp_last_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_x <= XW'(DEPTH))
      else $error("word count beyond depth");

   a_match_range: assert property (@(posedge clock) disable iff (reset)
      cmd.compare |=> ((match_ff >> count_ff) == '0))
      else $error("search matched a cell beyond the held words");

   a_disp_range: assert property (@(posedge clock) disable iff (reset)
      cmd.disp_step |-> (XW'(disp_idx_ff) < count_x))
      else $error("display index beyond the held words");

endmodule

`default_nettype wire

>>> hw/rtl/positional_array_insert_delete_unit.sv
// Insert, delete, update and other kinds are executed in the decode state, which loads the
// response register; search first registers the match vector in the decode state and loads
// the response in the search state; display gives one word per cycle while the response side keeps taking them.
// The controller takes one request at a time: a new request is taken only once the last
// response of the previous one has been loaded, after the decode step and the registered match vector.
// Reset clears the word count and the handshake state; the word cells are not cleared.
`default_nettype none

module positional_array_insert_delete_unit
   import paid_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // From bit 0: position (5), value (32), zero fill (3).
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // From bit 0: kind (3).
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // From bit 0: status (2), found_position (5), word (32), count (5), zero fill (4).
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   paid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   paid_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire
